@@ rtl/hrp_pkg.sv @@
// Package for the HTTP request header parser: state codes, field classes,
// status codes, byte constants and the character class functions.
// Depends on nothing; imported by every other file of the project.
package hrp_pkg;

    // Parser states of the request head.
    typedef enum logic [4:0] {
        PS_METHOD_START = 5'd0,
        PS_METHOD       = 5'd1,
        PS_URI          = 5'd2,
        PS_VER_H        = 5'd3,
        PS_VER_T1       = 5'd4,
        PS_VER_T2       = 5'd5,
        PS_VER_P        = 5'd6,
        PS_VER_SLASH    = 5'd7,
        PS_MAJOR_START  = 5'd8,
        PS_MAJOR        = 5'd9,
        PS_MINOR_START  = 5'd10,
        PS_MINOR        = 5'd11,
        PS_NL1          = 5'd12,
        PS_LINE_START   = 5'd13,
        PS_LWS          = 5'd14,
        PS_NAME         = 5'd15,
        PS_SP_VALUE     = 5'd16,
        PS_VALUE        = 5'd17,
        PS_NL2          = 5'd18,
        PS_NL3          = 5'd19
    } parse_state_t;

    // Status codes of a result beat.
    localparam logic [1:0] STAT_CONTINUE  = 2'd0;
    localparam logic [1:0] STAT_DONE      = 2'd1;
    localparam logic [1:0] STAT_MALFORMED = 2'd2;

    // Field classes of a result beat.
    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_METHOD = 3'd1;
    localparam logic [2:0] CLS_URI    = 3'd2;
    localparam logic [2:0] CLS_NAME   = 3'd3;
    localparam logic [2:0] CLS_VALUE  = 3'd4;

    // Matcher position once the name cannot be Host, and after a full match.
    localparam logic [2:0] NAME_MISS = 3'd7;
    localparam logic [2:0] NAME_FULL = 3'd4;

    // Version accumulator saturation value.
    localparam logic [9:0]  VER_MAX    = 10'd999;
    localparam logic [13:0] VER_MAX_W  = 14'd999;

    // Byte constants.
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CTL_MAX  = 8'h1F;
    localparam logic [7:0] CH_ASCII_MAX = 8'h7F;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        parse_state_t pstate;
        logic [9:0]   major_acc;
        logic [9:0]   minor_acc;
        logic         header_seen;
        logic [2:0]   name_match_pos;
        logic         name_is_host;
    } hrp_state_t;

    // One result beat.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] field_class;
        logic [7:0] byte_out;
        logic       new_header;
        logic       host_value;
        logic [9:0] version_major;
        logic [9:0] version_minor;
    } hrp_result_t;

    // Control characters.
    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= CH_CTL_MAX) || (b == CH_DEL);
    endfunction

    // Separator characters of the token grammar.
    function automatic logic is_special(input logic [7:0] b);
        logic r;
        unique case (b)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
            8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
            8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Token characters: printable ASCII that is not a separator.
    function automatic logic is_token(input logic [7:0] b);
        return (b <= CH_ASCII_MAX) && !is_ctl(b) && !is_special(b);
    endfunction

    function automatic logic is_num(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // The letters of "Host", by position.
    function automatic logic [7:0] host_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0: c = CH_H;
            2'd1: c = CH_LO_O;
            2'd2: c = CH_LO_S;
            default: c = CH_LO_T;
        endcase
        return c;
    endfunction

    // Decimal accumulate with saturation: acc * 10 + digit, capped at 999.
    function automatic logic [9:0] acc_digit(input logic [9:0] acc, input logic [7:0] b);
        logic [13:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {10'd0, b[3:0]};
        return (v > VER_MAX_W) ? VER_MAX : v[9:0];
    endfunction

endpackage

@@ rtl/hrp_step.sv @@
// One-byte step of the request head parser: next state and result beat.
// Purely combinational; uses the types and functions of hrp_pkg.
module hrp_step import hrp_pkg::*; (
    input  logic [7:0]  data_byte,
    input  hrp_state_t  cur,
    output hrp_state_t  nxt,
    output hrp_result_t res
);

    logic       bad;
    logic [1:0] status;
    logic [2:0] cls;
    logic       nh;
    logic       hv;
    hrp_state_t upd;

    // State transition for the current byte.
    always_comb begin
        upd    = cur;
        bad    = 1'b0;
        status = STAT_CONTINUE;
        cls    = CLS_NONE;
        nh     = 1'b0;
        hv     = 1'b0;
        unique case (cur.pstate)
            PS_METHOD_START: begin
                if (!is_token(data_byte)) begin
                    bad = 1'b1;
                end else begin
                    upd.pstate = PS_METHOD;
                    cls = CLS_METHOD;
                end
            end
            PS_METHOD: begin
                if (data_byte == CH_SP) upd.pstate = PS_URI;
                else if (!is_token(data_byte)) bad = 1'b1;
                else cls = CLS_METHOD;
            end
            PS_URI: begin
                if (data_byte == CH_SP) upd.pstate = PS_VER_H;
                else if (is_ctl(data_byte)) bad = 1'b1;
                else cls = CLS_URI;
            end
            PS_VER_H: begin
                if (data_byte == CH_H) upd.pstate = PS_VER_T1;
                else bad = 1'b1;
            end
            PS_VER_T1: begin
                if (data_byte == CH_T) upd.pstate = PS_VER_T2;
                else bad = 1'b1;
            end
            PS_VER_T2: begin
                if (data_byte == CH_T) upd.pstate = PS_VER_P;
                else bad = 1'b1;
            end
            PS_VER_P: begin
                if (data_byte == CH_P) upd.pstate = PS_VER_SLASH;
                else bad = 1'b1;
            end
            PS_VER_SLASH: begin
                if (data_byte == CH_SLASH) begin
                    upd.major_acc = '0;
                    upd.minor_acc = '0;
                    upd.pstate    = PS_MAJOR_START;
                end else begin
                    bad = 1'b1;
                end
            end
            PS_MAJOR_START: begin
                if (is_num(data_byte)) begin
                    upd.major_acc = acc_digit(cur.major_acc, data_byte);
                    upd.pstate    = PS_MAJOR;
                end else begin
                    bad = 1'b1;
                end
            end
            PS_MAJOR: begin
                if (data_byte == CH_DOT) upd.pstate = PS_MINOR_START;
                else if (is_num(data_byte)) upd.major_acc = acc_digit(cur.major_acc, data_byte);
                else bad = 1'b1;
            end
            PS_MINOR_START: begin
                if (is_num(data_byte)) begin
                    upd.minor_acc = acc_digit(cur.minor_acc, data_byte);
                    upd.pstate    = PS_MINOR;
                end else begin
                    bad = 1'b1;
                end
            end
            PS_MINOR: begin
                if (data_byte == CH_CR) upd.pstate = PS_NL1;
                else if (is_num(data_byte)) upd.minor_acc = acc_digit(cur.minor_acc, data_byte);
                else bad = 1'b1;
            end
            PS_NL1: begin
                if (data_byte == CH_LF) upd.pstate = PS_LINE_START;
                else bad = 1'b1;
            end
            PS_LINE_START: begin
                if (data_byte == CH_CR) begin
                    upd.pstate = PS_NL3;
                end else if (cur.header_seen && (data_byte == CH_SP || data_byte == CH_HT)) begin
                    upd.pstate = PS_LWS;
                end else if (!is_token(data_byte)) begin
                    bad = 1'b1;
                end else begin
                    // First byte of a new header name.
                    upd.header_seen    = 1'b1;
                    upd.name_is_host   = 1'b0;
                    upd.name_match_pos = (data_byte == CH_H) ? 3'd1 : NAME_MISS;
                    upd.pstate         = PS_NAME;
                    cls = CLS_NAME;
                    nh  = 1'b1;
                end
            end
            PS_LWS: begin
                if (data_byte == CH_CR) begin
                    upd.pstate = PS_NL2;
                end else if (data_byte == CH_SP || data_byte == CH_HT) begin
                    upd.pstate = PS_LWS;
                end else if (is_ctl(data_byte)) begin
                    bad = 1'b1;
                end else begin
                    upd.pstate = PS_VALUE;
                    cls = CLS_VALUE;
                    hv  = cur.name_is_host;
                end
            end
            PS_NAME: begin
                if (data_byte == CH_COLON) begin
                    upd.name_is_host = (cur.name_match_pos == NAME_FULL);
                    upd.pstate       = PS_SP_VALUE;
                end else if (!is_token(data_byte)) begin
                    bad = 1'b1;
                end else begin
                    // Track whether the name is still a prefix of "Host".
                    if (cur.name_match_pos < NAME_FULL
                        && data_byte == host_char(cur.name_match_pos[1:0])) begin
                        upd.name_match_pos = cur.name_match_pos + 3'd1;
                    end else begin
                        upd.name_match_pos = NAME_MISS;
                    end
                    cls = CLS_NAME;
                end
            end
            PS_SP_VALUE: begin
                if (data_byte == CH_SP) upd.pstate = PS_VALUE;
                else bad = 1'b1;
            end
            PS_VALUE: begin
                if (data_byte == CH_CR) begin
                    upd.pstate = PS_NL2;
                end else if (is_ctl(data_byte)) begin
                    bad = 1'b1;
                end else begin
                    cls = CLS_VALUE;
                    hv  = cur.name_is_host;
                end
            end
            PS_NL2: begin
                if (data_byte == CH_LF) upd.pstate = PS_LINE_START;
                else bad = 1'b1;
            end
            PS_NL3: begin
                if (data_byte == CH_LF) status = STAT_DONE;
                else bad = 1'b1;
            end
            default: begin
                bad = 1'b1;
            end
        endcase

        if (bad) begin
            status = STAT_MALFORMED;
            cls    = CLS_NONE;
            nh     = 1'b0;
            hv     = 1'b0;
        end
    end

    // Result beat and return to method start after done or malformed.
    always_comb begin
        res.status        = status;
        res.field_class   = cls;
        res.byte_out      = (cls != CLS_NONE) ? data_byte : 8'd0;
        res.new_header    = nh;
        res.host_value    = hv;
        res.version_major = upd.major_acc;
        res.version_minor = upd.minor_acc;

        nxt = upd;
        if (status != STAT_CONTINUE) begin
            nxt.pstate         = PS_METHOD_START;
            nxt.header_seen    = 1'b0;
            nxt.name_match_pos = 3'd0;
            nxt.name_is_host   = 1'b0;
        end
    end

endmodule

@@ rtl/http_request_header_parser.sv @@
// Top level of the HTTP request header parser: input register, parser state,
// result register and handshakes. Depends on hrp_pkg and hrp_step.
//
//   channel  | direction | ports                          | moves
//   s_       | in        | s_valid, s_ready, s_data_byte  | one request byte per beat
//   m_       | out       | m_valid, m_ready, m_status ... | one result per byte
//
// One byte per cycle sustained while m_ready stays high. Each byte passes from the
// input register through a single state update into the result register.
// Reset (aresetn, synchronous, low) puts the parser at method start with zero
// version counts. A stall on m_ready holds the result; the input register still
// takes one more beat before s_ready drops.
module http_request_header_parser import hrp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [2:0] m_field_class,
    output logic [7:0] m_byte_out,
    output logic       m_new_header,
    output logic       m_host_value,
    output logic [9:0] m_version_major,
    output logic [9:0] m_version_minor
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    hrp_result_t out_reg;
    hrp_state_t  state_reg;
    hrp_state_t  state_next;
    hrp_result_t res_next;
    logic        advance;

    // The step fires when a byte waits and the result register is free or being read out.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    hrp_step u_step (
        .data_byte (in_byte_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // Parser state, updated once for each byte that moves to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pstate         <= PS_METHOD_START;
            state_reg.major_acc      <= '0;
            state_reg.minor_acc      <= '0;
            state_reg.header_seen    <= 1'b0;
            state_reg.name_match_pos <= 3'd0;
            state_reg.name_is_host   <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_reg.status;
    assign m_field_class   = out_reg.field_class;
    assign m_byte_out      = out_reg.byte_out;
    assign m_new_header    = out_reg.new_header;
    assign m_host_value    = out_reg.host_value;
    assign m_version_major = out_reg.version_major;
    assign m_version_minor = out_reg.version_minor;

    // A done or malformed byte sends the parser back to method start.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_next.status != STAT_CONTINUE
        |=> state_reg.pstate == PS_METHOD_START && !state_reg.header_seen)
        else $error("parser did not return to method start");

    // A held result must not be overwritten while the sink stalls.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");

    // Host flag only on header value bytes, new header only on name bytes.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg
        |-> (!m_host_value || m_field_class == CLS_VALUE)
            && (!m_new_header || m_field_class == CLS_NAME))
        else $error("flag on wrong field class");

    // Version counts stay saturated.
    a_ver: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.major_acc <= VER_MAX && state_reg.minor_acc <= VER_MAX)
        else $error("version count above limit");

endmodule

@@ dv/hrp_parse_checker.sv @@
`timescale 1ns / 1ps
// Checker for the HTTP request header parser: follows the request bytes through its own
// parser, queues the tagged result of each byte and compares every result beat with it.
// Depends on hrp_pkg for the state codes, status codes, field classes and byte constants.
module hrp_parse_checker import hrp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_status,
    input  logic [2:0] m_field_class,
    input  logic [7:0] m_byte_out,
    input  logic       m_new_header,
    input  logic       m_host_value,
    input  logic [9:0] m_version_major,
    input  logic [9:0] m_version_minor,
    output int         fail_count,
    output int         pending
);

    localparam logic [7:0] HOST_LETTERS [4] = '{CH_H, CH_LO_O, CH_LO_S, CH_LO_T};

    // Our copy of the parser state.
    parse_state_t line_state;
    logic [9:0]   major_count;
    logic [9:0]   minor_count;
    logic         any_header;
    logic [2:0]   host_pos;
    logic         in_host;

    // Tagged results still owed by the block, oldest first.
    hrp_result_t  parse_results_q [$];
    int           beat_no;

    function automatic logic is_control_char(input logic [7:0] b);
        return (b < CH_SP) || (b == CH_DEL);
    endfunction

    function automatic logic is_separator(input logic [7:0] b);
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
            "/", "[", "]", "?", "=", "{", "}", CH_SP, CH_HT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_token_char(input logic [7:0] b);
        return !b[7] && !is_control_char(b) && !is_separator(b);
    endfunction

    function automatic logic is_decimal(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    // Decimal shift-in of one digit, held at the saturation value.
    function automatic logic [9:0] shift_in_digit(input logic [9:0] count, input logic [7:0] b);
        int sum;
        sum = int'(count) * 10 + int'(b - "0");
        return (sum > int'(VER_MAX)) ? VER_MAX : 10'(sum);
    endfunction

    task automatic restart_request();
        line_state = PS_METHOD_START;
        any_header = 1'b0;
        host_pos   = 3'd0;
        in_host    = 1'b0;
    endtask

    // Advances our parser by one byte and works out the result it owes.
    task automatic parse_request_byte(input logic [7:0] b, output hrp_result_t r);
        logic [1:0] st;
        logic [2:0] cls;
        logic       first_name;
        logic       host_byte;
        logic       bad;
        st = STAT_CONTINUE;
        cls = CLS_NONE;
        first_name = 1'b0;
        host_byte = 1'b0;
        bad = 1'b0;
        case (line_state)
            PS_METHOD_START: begin
                if (!is_token_char(b)) bad = 1'b1;
                else begin
                    line_state = PS_METHOD;
                    cls = CLS_METHOD;
                end
            end
            PS_METHOD: begin
                if (b == CH_SP) line_state = PS_URI;
                else if (!is_token_char(b)) bad = 1'b1;
                else cls = CLS_METHOD;
            end
            PS_URI: begin
                if (b == CH_SP) line_state = PS_VER_H;
                else if (is_control_char(b)) bad = 1'b1;
                else cls = CLS_URI;
            end
            PS_VER_H: begin
                if (b == CH_H) line_state = PS_VER_T1; else bad = 1'b1;
            end
            PS_VER_T1: begin
                if (b == CH_T) line_state = PS_VER_T2; else bad = 1'b1;
            end
            PS_VER_T2: begin
                if (b == CH_T) line_state = PS_VER_P; else bad = 1'b1;
            end
            PS_VER_P: begin
                if (b == CH_P) line_state = PS_VER_SLASH; else bad = 1'b1;
            end
            PS_VER_SLASH: begin
                if (b == CH_SLASH) begin
                    major_count = 10'd0;
                    minor_count = 10'd0;
                    line_state = PS_MAJOR_START;
                end else bad = 1'b1;
            end
            PS_MAJOR_START: begin
                if (is_decimal(b)) begin
                    major_count = shift_in_digit(major_count, b);
                    line_state = PS_MAJOR;
                end else bad = 1'b1;
            end
            PS_MAJOR: begin
                if (b == CH_DOT) line_state = PS_MINOR_START;
                else if (is_decimal(b)) major_count = shift_in_digit(major_count, b);
                else bad = 1'b1;
            end
            PS_MINOR_START: begin
                if (is_decimal(b)) begin
                    minor_count = shift_in_digit(minor_count, b);
                    line_state = PS_MINOR;
                end else bad = 1'b1;
            end
            PS_MINOR: begin
                if (b == CH_CR) line_state = PS_NL1;
                else if (is_decimal(b)) minor_count = shift_in_digit(minor_count, b);
                else bad = 1'b1;
            end
            PS_NL1: begin
                if (b == CH_LF) line_state = PS_LINE_START; else bad = 1'b1;
            end
            PS_LINE_START: begin
                // Leading whitespace only continues a value once some header exists.
                if (b == CH_CR) line_state = PS_NL3;
                else if (any_header && (b == CH_SP || b == CH_HT)) line_state = PS_LWS;
                else if (!is_token_char(b)) bad = 1'b1;
                else begin
                    any_header = 1'b1;
                    in_host = 1'b0;
                    host_pos = (b == HOST_LETTERS[0]) ? 3'd1 : NAME_MISS;
                    line_state = PS_NAME;
                    cls = CLS_NAME;
                    first_name = 1'b1;
                end
            end
            PS_LWS: begin
                if (b == CH_CR) line_state = PS_NL2;
                else if (b == CH_SP || b == CH_HT) line_state = PS_LWS;
                else if (is_control_char(b)) bad = 1'b1;
                else begin
                    line_state = PS_VALUE;
                    cls = CLS_VALUE;
                    host_byte = in_host;
                end
            end
            PS_NAME: begin
                if (b == CH_COLON) begin
                    in_host = (host_pos == NAME_FULL);
                    line_state = PS_SP_VALUE;
                end else if (!is_token_char(b)) bad = 1'b1;
                else begin
                    if (host_pos < NAME_FULL && b == HOST_LETTERS[host_pos[1:0]])
                        host_pos = host_pos + 3'd1;
                    else
                        host_pos = NAME_MISS;
                    cls = CLS_NAME;
                end
            end
            PS_SP_VALUE: begin
                if (b == CH_SP) line_state = PS_VALUE; else bad = 1'b1;
            end
            PS_VALUE: begin
                if (b == CH_CR) line_state = PS_NL2;
                else if (is_control_char(b)) bad = 1'b1;
                else begin
                    cls = CLS_VALUE;
                    host_byte = in_host;
                end
            end
            PS_NL2: begin
                if (b == CH_LF) line_state = PS_LINE_START; else bad = 1'b1;
            end
            PS_NL3: begin
                if (b == CH_LF) st = STAT_DONE; else bad = 1'b1;
            end
            default: bad = 1'b1;
        endcase

        // A malformed byte carries no tag.
        if (bad) begin
            st = STAT_MALFORMED;
            cls = CLS_NONE;
            first_name = 1'b0;
            host_byte = 1'b0;
        end
        r.status        = st;
        r.field_class   = cls;
        r.byte_out      = (cls != CLS_NONE) ? b : 8'd0;
        r.new_header    = first_name;
        r.host_value    = host_byte;
        r.version_major = major_count;
        r.version_minor = minor_count;
        if (st != STAT_CONTINUE) restart_request();
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] result beat %0d: %s is %0d, expected %0d", $realtime, beat_no, what,
                 got, want);
        fail_count++;
    endtask

    // Result beats are compared before the input beat of the same edge is queued, so a
    // stray result can never be matched against a byte that has only just gone in.
    always @(posedge aclk) begin : watch_channels
        hrp_result_t want;
        hrp_result_t got;
        if (!aresetn) begin
            restart_request();
            major_count = 10'd0;
            minor_count = 10'd0;
            parse_results_q.delete();
            beat_no = 0;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.status        = m_status;
                got.field_class   = m_field_class;
                got.byte_out      = m_byte_out;
                got.new_header    = m_new_header;
                got.host_value    = m_host_value;
                got.version_major = m_version_major;
                got.version_minor = m_version_minor;
                if (parse_results_q.size() == 0) begin
                    report_mismatch("unexpected result, queue depth", 0, 0);
                end else begin
                    want = parse_results_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.field_class !== want.field_class)
                        report_mismatch("field_class", got.field_class, want.field_class);
                    if (got.byte_out !== want.byte_out)
                        report_mismatch("byte_out", got.byte_out, want.byte_out);
                    if (got.new_header !== want.new_header)
                        report_mismatch("new_header", got.new_header, want.new_header);
                    if (got.host_value !== want.host_value)
                        report_mismatch("host_value", got.host_value, want.host_value);
                    if (got.version_major !== want.version_major)
                        report_mismatch("version_major", got.version_major,
                                        want.version_major);
                    if (got.version_minor !== want.version_minor)
                        report_mismatch("version_minor", got.version_minor,
                                        want.version_minor);
                end
                beat_no++;
            end
            if (s_valid && s_ready) begin
                parse_request_byte(s_data_byte, want);
                parse_results_q.insert(parse_results_q.size(), want);
            end
        end
        pending = parse_results_q.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the HTTP request header parser testbench: clock, reset, request byte stimulus
// and result back-pressure, with hrp_parse_checker beside the block doing the checking.
// Depends on hrp_pkg, http_request_header_parser and hrp_parse_checker.
module tb_top import hrp_pkg::*;;

    localparam int PHASE_BYTES = 235;
    localparam int LONG_HOLD   = 200;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_status;
    logic [2:0] m_field_class;
    logic [7:0] m_byte_out;
    logic       m_new_header;
    logic       m_host_value;
    logic [9:0] m_version_major;
    logic [9:0] m_version_minor;
    int         fail_count;
    int         pending;

    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    logic       rx_hold = 1'b0;
    int         bytes_sent = 0;
    logic [7:0] request_q [$];
    string      token_chars =
        "!#$%&'*+-.^_|~0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

    always #4 aclk = ~aclk;

    http_request_header_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_field_class   (m_field_class),
        .m_byte_out      (m_byte_out),
        .m_new_header    (m_new_header),
        .m_host_value    (m_host_value),
        .m_version_major (m_version_major),
        .m_version_minor (m_version_minor)
    );

    hrp_parse_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_field_class   (m_field_class),
        .m_byte_out      (m_byte_out),
        .m_new_header    (m_new_header),
        .m_host_value    (m_host_value),
        .m_version_major (m_version_major),
        .m_version_minor (m_version_minor),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // Offers one byte, idling beforehand at the current rate, and returns once it is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Appends one byte to the stimulus queue.
    task automatic add_byte(input logic [7:0] b);
        request_q.insert(request_q.size(), b);
    endtask

    task automatic push_text(input string text);
        for (int i = 0; i < text.len(); i++) add_byte(text[i]);
    endtask

    function automatic logic [7:0] pick_token();
        return token_chars[$urandom_range(token_chars.len() - 1)];
    endfunction

    // Printable or high byte, as allowed in a header value.
    function automatic logic [7:0] pick_value_char();
        logic [7:0] b;
        b = 8'($urandom_range(32, 255));
        return (b == CH_DEL) ? CH_SP : b;
    endfunction

    function automatic logic [7:0] pick_uri_char();
        logic [7:0] b;
        b = 8'($urandom_range(33, 255));
        return (b == CH_DEL) ? CH_SLASH : b;
    endfunction

    task automatic push_digits();
        int n;
        n = ($urandom_range(7) == 0) ? 4 : $urandom_range(1, 2);
        repeat (n) add_byte(8'("0" + $urandom_range(9)));
    endtask

    // Builds the next stretch of stimulus: mostly well-formed request heads with random
    // content, some with a corrupted byte or a cut-off tail, and now and then plain noise.
    task automatic build_request();
        int lines;
        int cut;
        request_q.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(1, 4)) add_byte(pick_token());
        add_byte(CH_SP);
        repeat ($urandom_range(0, 5)) add_byte(pick_uri_char());
        add_byte(CH_SP);
        push_text("HTTP/");
        push_digits();
        add_byte(CH_DOT);
        push_digits();
        add_byte(CH_CR);
        add_byte(CH_LF);
        lines = $urandom_range(0, 3);
        for (int i = 0; i < lines; i++) begin
            if ($urandom_range(4) == 0) begin
                // Continuation line; malformed when no header has been seen yet.
                repeat ($urandom_range(1, 2))
                    add_byte($urandom_range(1) ? CH_SP : CH_HT);
                repeat ($urandom_range(0, 4)) add_byte(pick_value_char());
            end else begin
                case ($urandom_range(5))
                    0, 1: push_text("Host");
                    2: push_text("Hos");
                    3: push_text("Hostx");
                    4: push_text("host");
                    default: repeat ($urandom_range(1, 5)) add_byte(pick_token());
                endcase
                add_byte(CH_COLON);
                add_byte(CH_SP);
                repeat ($urandom_range(0, 5)) add_byte(pick_value_char());
            end
            add_byte(CH_CR);
            add_byte(CH_LF);
        end
        add_byte(CH_CR);
        add_byte(CH_LF);
        if ($urandom_range(4) == 0)
            request_q[$urandom_range(request_q.size() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, request_q.size() - 1);
            while (request_q.size() > cut) void'(request_q.pop_back());
        end
    endtask

    task automatic send_queued();
        foreach (request_q[i]) send_byte(request_q[i]);
    endtask

    // One phase of random requests at the given idle rates, then drain.
    task automatic run_phase(input int tx_pct, input int rx_pct, input logic long_hold);
        int target;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = bytes_sent + PHASE_BYTES;
        if (long_hold) rx_hold = 1'b1;
        while (bytes_sent < target) begin
            build_request();
            send_queued();
        end
        s_valid <= 1'b0;
        // The edge wait lets the checker count the last beat before the drain is awaited.
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
                rx_hold = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: control and high bytes where tokens are due, a high byte in the URI
        // and in a Host value, a whitespace-only continuation line and a complete head.
        tx_idle_pct = 26;
        rx_idle_pct = 51;
        request_q.delete();
        add_byte(8'h00);
        push_text("G");
        add_byte(8'hFF);
        push_text("x /");
        add_byte(8'hFF);
        push_text(" HTTP/1.1");
        add_byte(CH_CR);
        add_byte(CH_LF);
        push_text("Host: ");
        add_byte(8'h80);
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(CH_HT);
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(CH_CR);
        add_byte(CH_LF);
        send_queued();
        s_valid <= 1'b0;
        // The sender waits here for every outstanding result.
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);

        run_phase(26, 51, 1'b1);
        run_phase(51, 26, 1'b0);
        run_phase(0, 0, 1'b0);

        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
